### rtl/lmpsd_pkg.sv
// lmpsd_pkg: shared types, constants and small helper functions for the led matrix
// pwm scan driver; used by lmpsd_pack, the top level and the testbench, depends on nothing
package lmpsd_pkg;

  localparam int unsigned PanelWidth  = 24;
  localparam int unsigned PanelHeight = 16;
  localparam int unsigned StoreDepth  = PanelWidth * PanelHeight;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned ColW        = 96;
  localparam int unsigned ColIdxW     = $clog2(ColW);
  localparam int unsigned PixPerTick  = 48;

  // configuration register indexes
  localparam logic [7:0] REG_FOUR_BIT_CODE = 8'd0;
  localparam logic [7:0] REG_TWO_BIT_CODE  = 8'd1;

  // write limits and duty limits per format
  localparam logic [AddrW-1:0] LIMIT_FOUR  = AddrW'(StoreDepth);
  localparam logic [AddrW-1:0] LIMIT_TWO   = AddrW'(PanelWidth * (PanelHeight >> 1));
  localparam logic [AddrW-1:0] LIMIT_OTHER = AddrW'(PanelWidth * (PanelHeight >> 2));
  localparam logic [3:0] DUTY_FOUR  = 4'd15;
  localparam logic [3:0] DUTY_TWO   = 4'd3;
  localparam logic [3:0] DUTY_OTHER = 4'd1;

  typedef enum logic [1:0] {
    FMT_FOUR  = 2'd0,
    FMT_TWO   = 2'd1,
    FMT_OTHER = 2'd2
  } fmt_e;

  // control from the sequencer to the pixel compare unit
  typedef struct packed {
    logic       clr;
    logic       en;
    logic [5:0] step;
  } pack_ctl_t;

  // frame store entry for a step of the scan: step = group * 8 + pixel
  function automatic logic [AddrW-1:0] scan_addr(input logic [2:0] row,
                                                 input logic [5:0] step);
    logic [2:0] grp;
    logic [1:0] gcol;
    logic       upper;
    begin
      grp   = step[5:3];
      upper = (grp < 3'd3);
      gcol  = upper ? grp[1:0] : 2'(grp - 3'd3);
      // column = 8 * (gcol + 1) - 1 - row
      scan_addr = {gcol, ~row, upper, step[2:0]};
    end
  endfunction

  // which byte of the group pair a pixel lands in
  function automatic logic pix_byte(input logic [2:0] k);
    begin
      pix_byte = ~k[1];
    end
  endfunction

  function automatic logic [2:0] pix_gpos(input logic [2:0] k);
    logic [2:0] pos;
    begin
      case (k)
        3'd0, 3'd2: pos = 3'd6;
        3'd1, 3'd3: pos = 3'd0;
        3'd4, 3'd6: pos = 3'd5;
        default:    pos = 3'd3;
      endcase
      pix_gpos = pos;
    end
  endfunction

  function automatic logic [2:0] pix_rpos(input logic [2:0] k);
    logic [2:0] pos;
    begin
      case (k)
        3'd0, 3'd2: pos = 3'd7;
        3'd1, 3'd3: pos = 3'd1;
        3'd4, 3'd6: pos = 3'd4;
        default:    pos = 3'd2;
      endcase
      pix_rpos = pos;
    end
  endfunction

endpackage

### rtl/lmpsd_ram.sv
// lmpsd_ram: generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module lmpsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lmpsd_pack.sv
// lmpsd_pack: shared duty compare unit and 96 bit column accumulator
// depends on lmpsd_pkg
module lmpsd_pack (
  input  logic                                clk_i,
  input  lmpsd_pkg::pack_ctl_t                ctl_i,
  input  logic [7:0]                          rdata_i,
  input  logic [3:0]                          duty_i,
  output logic [lmpsd_pkg::ColW-1:0]          acc_o
);

  logic [lmpsd_pkg::ColW-1:0]    acc_q, acc_d;
  logic [lmpsd_pkg::ColIdxW-1:0] gidx, ridx;
  logic [3:0]                    byte_sel;
  logic                          g_on, r_on;

  // byte of the shift data is 2 * group + pixel byte
  assign byte_sel = {ctl_i.step[5:3], lmpsd_pkg::pix_byte(ctl_i.step[2:0])};
  assign gidx = {byte_sel, lmpsd_pkg::pix_gpos(ctl_i.step[2:0])};
  assign ridx = {byte_sel, lmpsd_pkg::pix_rpos(ctl_i.step[2:0])};

  assign g_on = (rdata_i[7:4] > duty_i);
  assign r_on = (rdata_i[3:0] > duty_i);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.en) begin
      acc_d[gidx] = acc_q[gidx] | g_on;
      acc_d[ridx] = acc_q[ridx] | r_on;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### rtl/led_matrix_pwm_scan_driver_unit.sv
// led matrix pwm scan driver: a two-bit format bus byte takes a second frame store write,
// with input stalled; a scan tick reads 48 frame store entries, one per cycle through the
// single read port, and input stays stalled until its result is taken into the output
// register; after reset a clearing pass writes zero to all 384 frame store entries, during
// which no input is taken (config is)
// depends on lmpsd_pkg, lmpsd_ram and lmpsd_pack
module led_matrix_pwm_scan_driver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [9:0]  byte_index_i,
  input  logic [7:0]  data_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] column_bits_low_o,
  output logic [47:0] column_bits_high_o,
  output logic [7:0]  row_drive_o
);

  localparam int unsigned AW = lmpsd_pkg::AddrW;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WRITE2 = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [7:0] four_code_q, two_code_q;

  // format state
  lmpsd_pkg::fmt_e fmt_q, fmt_d;
  logic [AW-1:0]   limit_q, limit_d;
  logic [3:0]      duty_lim_q, duty_lim_d;
  logic [2:0]      row_q, row_d;
  logic [3:0]      duty_q, duty_d;

  // step counter, shared by the clearing pass and the scan
  logic [AW-1:0] cnt_q, cnt_d;

  // pending second write of a two-bit byte
  logic [AW-1:0] wr2_addr_q, wr2_addr_d;
  logic [7:0]    wr2_data_q, wr2_data_d;

  // read pipeline tag
  logic       pv_q;
  logic [5:0] pstep_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [47:0] col_lo_q, col_hi_q;
  logic [7:0]  row_drv_q;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic                           in_xfer, out_xfer, load_out;
  logic [9:0]                     idx_m1;
  logic [4:0]                     duty_inc;
  logic [lmpsd_pkg::ColW-1:0]     acc;
  lmpsd_pkg::pack_ctl_t           pack_ctl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign idx_m1      = byte_index_i - 10'd1;
  assign duty_inc    = {1'b0, duty_q} + 5'd1;

  // result leaves the accumulator once the last read has been packed
  assign load_out = (state_q == ST_OUT) && !pv_q && (!out_valid_q || !out_stall_i);

  // configuration writes, taken in any state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_code_q <= 8'd0;
      two_code_q  <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lmpsd_pkg::REG_FOUR_BIT_CODE: four_code_q <= cfg_data_i;
        lmpsd_pkg::REG_TWO_BIT_CODE:  two_code_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fmt_d       = fmt_q;
    limit_d     = limit_q;
    duty_lim_d  = duty_lim_q;
    row_d       = row_q;
    duty_d      = duty_q;
    cnt_d       = cnt_q;
    wr2_addr_d  = wr2_addr_q;
    wr2_data_d  = wr2_data_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = 8'd0;
    ram_raddr   = lmpsd_pkg::scan_addr(row_q, cnt_q[5:0]);
    pack_ctl.clr  = 1'b0;
    pack_ctl.en   = pv_q;
    pack_ctl.step = pstep_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // zero one frame store entry per cycle
        ram_we = 1'b1;
        if (cnt_q == AW'(lmpsd_pkg::StoreDepth - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_i) begin
            // scan tick
            pack_ctl.clr = 1'b1;
            cnt_d        = '0;
            state_d      = ST_SCAN;
          end else if (byte_index_i == 10'd0) begin
            // format header, four-bit code wins a tie
            if (data_byte_i == four_code_q) begin
              fmt_d      = lmpsd_pkg::FMT_FOUR;
              limit_d    = lmpsd_pkg::LIMIT_FOUR;
              duty_lim_d = lmpsd_pkg::DUTY_FOUR;
            end else if (data_byte_i == two_code_q) begin
              fmt_d      = lmpsd_pkg::FMT_TWO;
              limit_d    = lmpsd_pkg::LIMIT_TWO;
              duty_lim_d = lmpsd_pkg::DUTY_TWO;
            end else begin
              fmt_d      = lmpsd_pkg::FMT_OTHER;
              limit_d    = lmpsd_pkg::LIMIT_OTHER;
              duty_lim_d = lmpsd_pkg::DUTY_OTHER;
            end
          end else if (byte_index_i <= {1'b0, limit_q}) begin
            case (fmt_q)
              lmpsd_pkg::FMT_FOUR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[AW-1:0];
                ram_wdata = data_byte_i;
              end
              lmpsd_pkg::FMT_TWO: begin
                // upper pixel pair now, lower pair next cycle
                ram_we     = 1'b1;
                ram_waddr  = {idx_m1[AW-2:0], 1'b0};
                ram_wdata  = {2'b00, data_byte_i[7:6], 2'b00, data_byte_i[5:4]};
                wr2_addr_d = {idx_m1[AW-2:0], 1'b1};
                wr2_data_d = {2'b00, data_byte_i[3:2], 2'b00, data_byte_i[1:0]};
                state_d    = ST_WRITE2;
              end
              default: ;  // other format: payload dropped
            endcase
          end
        end
      end
      ST_WRITE2: begin
        ram_we    = 1'b1;
        ram_waddr = wr2_addr_q;
        ram_wdata = wr2_data_q;
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        // issue one frame store read per cycle
        if (cnt_q[5:0] == 6'(lmpsd_pkg::PixPerTick - 1)) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          row_d       = row_q + 3'd1;
          if (row_q == 3'd7) begin
            // duty count wraps at the format's limit
            if (duty_inc >= {1'b0, duty_lim_q}) begin
              duty_d = 4'd0;
            end else begin
              duty_d = duty_inc[3:0];
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fmt_q       <= lmpsd_pkg::FMT_FOUR;
      limit_q     <= '0;
      duty_lim_q  <= 4'd0;
      row_q       <= 3'd0;
      duty_q      <= 4'd0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fmt_q       <= fmt_d;
      limit_q     <= limit_d;
      duty_lim_q  <= duty_lim_d;
      row_q       <= row_d;
      duty_q      <= duty_d;
      cnt_q       <= cnt_d;
      pv_q        <= (state_q == ST_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    wr2_addr_q <= wr2_addr_d;
    wr2_data_q <= wr2_data_d;
    pstep_q    <= cnt_q[5:0];
    if (load_out) begin
      col_lo_q  <= acc[47:0];
      col_hi_q  <= acc[95:48];
      row_drv_q <= ~(8'd1 << row_q);
    end
  end

  lmpsd_ram #(
    .WIDTH (8),
    .DEPTH (lmpsd_pkg::StoreDepth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lmpsd_pack u_pack (
    .clk_i   (clk_i),
    .ctl_i   (pack_ctl),
    .rdata_i (ram_rdata),
    .duty_i  (duty_q),
    .acc_o   (acc)
  );

  assign out_valid_o        = out_valid_q;
  assign column_bits_low_o  = col_lo_q;
  assign column_bits_high_o = col_hi_q;
  assign row_drive_o        = row_drv_q;

`ifndef NO_ASSERTIONS
  // a new result only appears out of the output state
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  // the frame store is never written while a scan is reading it
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !(state_q == ST_SCAN || state_q == ST_OUT))
    else $error("frame store write during scan");

  // every result advances the row by one
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> row_q == 3'($past(row_q) + 3'd1))
    else $error("row did not advance");

  // duty count only moves when the last row of a sweep goes out
  a_duty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_out && row_q == 3'd7) |=> duty_q == $past(duty_q))
    else $error("duty count moved mid sweep");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for led_matrix_pwm_scan_driver_unit, with its own
// frame store, format decode and row scan prediction, random idling on both channels
// depends on lmpsd_pkg and the scan driver rtl
module testbench;

  localparam logic        MODE_BUS       = 1'b0;
  localparam logic        MODE_TICK      = 1'b1;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 350;

  // one input transfer; calm marks items sent with no idling on either side
  typedef struct packed {
    logic       mode;
    logic [9:0] index;
    logic [7:0] data;
    logic       calm;
  } bus_item_t;

  // one scanned row as it should leave the block
  typedef struct packed {
    logic [47:0] low;
    logic [47:0] high;
    logic [7:0]  rows;
  } scan_line_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        mode_i       = MODE_BUS;
  logic [9:0]  byte_index_i = '0;
  logic [7:0]  data_byte_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [47:0] column_bits_low_o;
  logic [47:0] column_bits_high_o;
  logic [7:0]  row_drive_o;

  led_matrix_pwm_scan_driver_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .byte_index_i       (byte_index_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .column_bits_low_o  (column_bits_low_o),
    .column_bits_high_o (column_bits_high_o),
    .row_drive_o        (row_drive_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction state: frame store, format decode, row and duty counters
  // ---------------------------------------------------------------------------
  logic [7:0]                  pix_store [lmpsd_pkg::StoreDepth];
  lmpsd_pkg::fmt_e             cur_fmt       = lmpsd_pkg::FMT_FOUR;
  logic [lmpsd_pkg::AddrW-1:0] wr_limit      = '0;
  logic [3:0]                  pwm_limit     = '0;
  logic [2:0]                  row_ptr       = '0;
  logic [3:0]                  pwm_step      = '0;
  logic [7:0]                  cfg_four_code = 8'h00;
  logic [7:0]                  cfg_two_code  = 8'h01;

  bus_item_t  queued_items [$];
  scan_line_t expected_lines [$];

  // bookkeeping
  int unsigned mismatches   = 0;
  int unsigned items_in     = 0;
  int unsigned ticks_in     = 0;
  int unsigned lines_seen   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned useful_items = 0;
  int unsigned quiet_cycles = 0;
  logic        burst_calm   = 1'b0;
  logic        recv_calm    = 1'b0;

  task automatic note_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // header decode and frame store writes for a received bus byte
  task automatic apply_bus_byte(input logic [9:0] idx, input logic [7:0] v);
    int unsigned slot;
    if (idx == 10'd0) begin
      // four-bit code is checked first, so it wins when both codes match
      if (v == cfg_four_code) begin
        cur_fmt   = lmpsd_pkg::FMT_FOUR;
        wr_limit  = lmpsd_pkg::LIMIT_FOUR;
        pwm_limit = lmpsd_pkg::DUTY_FOUR;
      end else if (v == cfg_two_code) begin
        cur_fmt   = lmpsd_pkg::FMT_TWO;
        wr_limit  = lmpsd_pkg::LIMIT_TWO;
        pwm_limit = lmpsd_pkg::DUTY_TWO;
      end else begin
        cur_fmt   = lmpsd_pkg::FMT_OTHER;
        wr_limit  = lmpsd_pkg::LIMIT_OTHER;
        pwm_limit = lmpsd_pkg::DUTY_OTHER;
      end
    end else if (idx <= wr_limit) begin
      slot = idx - 1;
      if (cur_fmt == lmpsd_pkg::FMT_FOUR) begin
        if (slot < lmpsd_pkg::StoreDepth) pix_store[slot] = v;
      end else if (cur_fmt == lmpsd_pkg::FMT_TWO && 2 * slot + 1 < lmpsd_pkg::StoreDepth) begin
        // ggrrggrr: upper pair to the first pixel, lower pair to the second
        pix_store[2 * slot]     = {2'b00, v[7:6], 2'b00, v[5:4]};
        pix_store[2 * slot + 1] = {2'b00, v[3:2], 2'b00, v[1:0]};
      end
      // other format: payload dropped
    end
  endtask

  // compare 48 pixels of the current row against the duty count, then advance
  function automatic scan_line_t scan_next_row();
    scan_line_t  line;
    logic [7:0]  shift_byte [12];
    logic [7:0]  pix;
    logic [7:0]  gbit;
    logic [7:0]  rbit;
    logic [4:0]  next_step;
    int unsigned g;
    int unsigned k;
    int unsigned col;
    int unsigned base;
    int unsigned sel;
    line = '0;
    for (g = 0; g < 12; g++) shift_byte[g] = 8'h00;
    for (g = 0; g < 6; g++) begin
      // groups 0..2 take the upper half of a column, 3..5 the lower half
      col  = 8 * (g % 3 + 1) - 1 - row_ptr;
      base = col * lmpsd_pkg::PanelHeight + ((g < 3) ? 8 : 0);
      for (k = 0; k < 8; k++) begin
        pix  = pix_store[base + k];
        sel  = 2 * g + (((k & 2) != 0) ? 0 : 1);
        gbit = ((k & 1) != 0) ? (((k & 4) != 0) ? 8'h08 : 8'h01)
                              : (((k & 4) != 0) ? 8'h20 : 8'h40);
        rbit = ((k & 1) != 0) ? (((k & 4) != 0) ? 8'h04 : 8'h02)
                              : (((k & 4) != 0) ? 8'h10 : 8'h80);
        if (pix[7:4] > pwm_step) shift_byte[sel] |= gbit;
        if (pix[3:0] > pwm_step) shift_byte[sel] |= rbit;
      end
    end
    for (g = 0; g < 6; g++) begin
      line.low[8 * g +: 8]  = shift_byte[g];
      line.high[8 * g +: 8] = shift_byte[g + 6];
    end
    line.rows = ~(8'h01 << row_ptr);
    // duty count steps once per full sweep and wraps at the limit, a zero limit too
    if (row_ptr == 3'd7) begin
      next_step = pwm_step + 5'd1;
      pwm_step  = (next_step >= {1'b0, pwm_limit}) ? 4'd0 : next_step[3:0];
    end
    row_ptr = row_ptr + 3'd1;
    return line;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic m, input logic [9:0] idx, input logic [7:0] d);
    bus_item_t it;
    it.mode  = m;
    it.index = idx;
    it.data  = d;
    it.calm  = burst_calm;
    queued_items.push_back(it);
  endtask

  // scan tick with junk in the unused payload fields
  task automatic push_tick();
    push_item(MODE_TICK, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    useful_items++;
  endtask

  // header followed by an in-order run of payload bytes, ticks sprinkled in
  task automatic load_burst(input logic [7:0] hdr, input int unsigned first,
                            input int unsigned last, input logic counts);
    int unsigned i;
    push_item(MODE_BUS, 10'd0, hdr);
    useful_items++;
    for (i = first; i <= last; i++) begin
      push_item(MODE_BUS, 10'(i), 8'($urandom_range(0, 255)));
      if (counts) useful_items++;
      if ($urandom_range(0, 5) == 0) push_tick();
    end
  endtask

  task automatic queue_directed();
    int unsigned i;
    @(negedge clk_i);
    burst_calm = 1'b0;
    push_item(MODE_BUS, 10'd1, 8'hFF);               // payload before any header
    for (i = 0; i < 8; i++) push_tick();             // full sweep with zero duty limit
    push_item(MODE_BUS, 10'd0, cfg_four_code);
    push_item(MODE_BUS, 10'd1, 8'hFF);
    push_item(MODE_BUS, 10'(lmpsd_pkg::LIMIT_FOUR), 8'hF0);     // last store entry
    push_item(MODE_BUS, 10'(lmpsd_pkg::LIMIT_FOUR + 1), 8'hAA); // just past the limit
    push_item(MODE_BUS, 10'h3FF, 8'h55);             // top of the index range
    push_tick();
    push_item(MODE_BUS, 10'd0, cfg_two_code);
    push_item(MODE_BUS, 10'd1, 8'hFF);
    push_item(MODE_BUS, 10'(lmpsd_pkg::LIMIT_TWO), 8'hA5);
    push_item(MODE_BUS, 10'(lmpsd_pkg::LIMIT_TWO + 1), 8'h3C);
    push_tick();
    push_item(MODE_BUS, 10'd0, 8'h7E);               // unknown code, payload dropped
    push_item(MODE_BUS, 10'd1, 8'hFF);
    push_tick();
    push_item(MODE_BUS, 10'd0, cfg_four_code);
    push_tick();
  endtask

  task automatic queue_random(input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    int unsigned first;
    int unsigned last;
    int unsigned n;
    int unsigned i;
    logic [7:0]  hdr;
    @(negedge clk_i);
    goal = useful_items + budget;
    while (useful_items < goal) begin
      burst_calm = ($urandom_range(0, 4) == 0);
      pick       = $urandom_range(0, 9);
      if (pick < 4) begin
        last  = ($urandom_range(0, 11) == 0) ? lmpsd_pkg::LIMIT_FOUR
                                             : $urandom_range(1, 64);
        first = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, last);
        load_burst(cfg_four_code, first, last, 1'b1);
      end else if (pick < 6) begin
        last  = ($urandom_range(0, 7) == 0) ? lmpsd_pkg::LIMIT_TWO
                                            : $urandom_range(1, 48);
        first = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, last);
        load_burst(cfg_two_code, first, last, 1'b1);
      end else if (pick == 6) begin
        do hdr = 8'($urandom_range(0, 255));
        while (hdr == cfg_four_code || hdr == cfg_two_code);
        load_burst(hdr, 1, $urandom_range(1, 12), 1'b0);
      end else if (pick == 7) begin
        // noise: any mode, any index, stray headers included
        for (i = 0; i < 8; i++)
          push_item(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                    8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(8, 24);
        for (i = 0; i < n; i++) push_tick();
      end
    end
  endtask

  // sender holds off until every transfer is in and every line is out
  task automatic wait_idle();
    while (queued_items.size() != 0 || in_valid_i || expected_lines.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == lmpsd_pkg::REG_FOUR_BIT_CODE) cfg_four_code = value;
    else if (idx == lmpsd_pkg::REG_TWO_BIT_CODE) cfg_two_code = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transfer at a time from the queue, random gap before each
  // ---------------------------------------------------------------------------
  bus_item_t   drive_item;
  logic        gap_drawn = 1'b0;
  logic        load_valid;
  int unsigned gap_left  = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        items_in++;
        if (drive_item.mode == MODE_TICK) begin
          ticks_in++;
          expected_lines.push_back(scan_next_row());
        end else begin
          apply_bus_byte(drive_item.index, drive_item.data);
        end
      end
      // payload only moves when nothing is held or the held one just went
      if (!in_valid_i || !in_stall_o) begin
        load_valid = 1'b0;
        if (!gap_drawn && queued_items.size() != 0) begin
          gap_left  = queued_items[0].calm ? 0 : $urandom_range(0, 3);
          gap_drawn = 1'b1;
        end
        if (gap_drawn) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            drive_item   = queued_items.pop_front();
            mode_i       <= drive_item.mode;
            byte_index_i <= drive_item.index;
            data_byte_i  <= drive_item.data;
            recv_calm    = drive_item.calm;
            load_valid   = 1'b1;
            gap_drawn    = 1'b0;
          end
        end
        in_valid_i <= load_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each scan line against the oldest prediction, random stall
  // ---------------------------------------------------------------------------
  scan_line_t  want_line;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        lines_seen++;
        if (expected_lines.size() == 0) begin
          note_mismatch("result with nothing expected", column_bits_low_o, 48'd0);
        end else begin
          want_line = expected_lines.pop_front();
          if (column_bits_low_o !== want_line.low)
            note_mismatch("column_bits_low", column_bits_low_o, want_line.low);
          if (column_bits_high_o !== want_line.high)
            note_mismatch("column_bits_high", column_bits_high_o, want_line.high);
          if (row_drive_o !== want_line.rows)
            note_mismatch("row_drive", {40'd0, row_drive_o}, {40'd0, want_line.rows});
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog: cycles in a row with no transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d lines outstanding",
             quiet_cycles, expected_lines.size());
    $display("led_matrix_pwm_scan_driver_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence: reset codes first, then extreme, equal, random and swapped extreme codes
  // ---------------------------------------------------------------------------
  int unsigned phase;
  int unsigned s;
  logic [7:0]  four_sel;
  logic [7:0]  two_sel;

  initial begin
    for (s = 0; s < lmpsd_pkg::StoreDepth; s++) pix_store[s] = 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset codes: directed corner cases, then random traffic
    queue_directed();
    queue_random(PHASE_ITEMS);
    wait_idle();

    for (phase = 1; phase < 5; phase++) begin
      case (phase)
        1: begin
          four_sel = 8'hFF;
          two_sel  = 8'h00;
        end
        2: begin
          // both codes equal: four-bit format takes precedence
          four_sel = 8'h80;
          two_sel  = 8'h80;
        end
        3: begin
          four_sel = 8'($urandom_range(0, 255));
          two_sel  = 8'($urandom_range(0, 255));
        end
        default: begin
          four_sel = 8'h00;
          two_sel  = 8'hFF;
        end
      endcase
      write_register(lmpsd_pkg::REG_FOUR_BIT_CODE, four_sel);
      write_register(lmpsd_pkg::REG_TWO_BIT_CODE, two_sel);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("covered %0d input transfers, %0d of them scan ticks, %0d scan lines checked",
             items_in, ticks_in, lines_seen);
    $display("%0d register writes over 5 code settings, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("led_matrix_pwm_scan_driver_unit verification clean");
    end else begin
      $display("led_matrix_pwm_scan_driver_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/lmpsd_pkg.sv
rtl/lmpsd_ram.sv
rtl/lmpsd_pack.sv
rtl/led_matrix_pwm_scan_driver_unit.sv
dv/testbench.sv
